>>> rtl/ttsc_pkg.sv
// shared types and constants for the tone timer setting calculator
package ttsc_pkg;

	localparam int DATA_W     = 32;
	localparam int DIV_STEPS  = DATA_W;
	localparam int PRESCALE_W = 17;
	localparam int PERIOD_W   = 16;
	localparam int COMPARE_W  = 15;
	localparam int ADDR_W     = 3;
	localparam int REG_IDX_W  = ADDR_W - 2;

	// the limit is 2^LIMIT_W - 1; the folding divide needs LIMIT_W of 16 or more
	localparam int LIMIT_W = 16;

	// largest auto-reload count before the prescaler kicks in
	localparam logic [DATA_W-1:0] PERIOD_LIMIT = {{(DATA_W-LIMIT_W){1'b0}}, {LIMIT_W{1'b1}}};
	localparam logic [DATA_W-1:0] CLOCK_RESET  = 32'd16000000;

	// folded sum thresholds for one and two extra multiples of the limit
	localparam logic [LIMIT_W:0] FOLD_ONE = {1'b0, {LIMIT_W{1'b1}}};
	localparam logic [LIMIT_W:0] FOLD_TWO = {{LIMIT_W{1'b1}}, 1'b0};

	localparam logic [PRESCALE_W-1:0] PRESCALE_MAX = '1;
	localparam logic [PERIOD_W-1:0]   PERIOD_MAX   = '1;

	// register index decode
	localparam logic [REG_IDX_W-1:0] REG_CLOCK_HZ = '0;

	// sideband that travels alongside each request through a divider chain
	typedef struct packed {
		logic              valid;
		logic              off;
		logic [DATA_W-1:0] aux;
	} ttsc_side_t;

	// state held by one restoring divider cell
	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] dvd;
		logic [DATA_W-1:0] quo;
		logic [DATA_W-1:0] dvs;
		ttsc_side_t        side;
	} ttsc_div_t;

endpackage

>>> rtl/ttsc_div_cell.sv
// one restoring division step, registered
module ttsc_div_cell
	import ttsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  ttsc_div_t d,
	output ttsc_div_t q
);

	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic              take;
	ttsc_div_t         nxt;

	logic              valid_q;
	logic              off_q;
	logic [DATA_W-1:0] aux_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvd_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;

	// shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {d.rem, d.dvd[DATA_W-1]};
		diff  = trial - {1'b0, d.dvs};
		take  = (trial >= {1'b0, d.dvs});
		nxt          = d;
		nxt.rem      = take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
		nxt.dvd      = {d.dvd[DATA_W-2:0], 1'b0};
		nxt.quo      = {d.quo[DATA_W-2:0], take};
	end

	// control bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= nxt.side.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= nxt.rem;
			dvd_q <= nxt.dvd;
			quo_q <= nxt.quo;
			dvs_q <= nxt.dvs;
			off_q <= nxt.side.off;
			aux_q <= nxt.side.aux;
		end
	end

	always_comb begin
		q.rem        = rem_q;
		q.dvd        = dvd_q;
		q.quo        = quo_q;
		q.dvs        = dvs_q;
		q.side.valid = valid_q;
		q.side.off   = off_q;
		q.side.aux   = aux_q;
	end

endmodule

>>> rtl/ttsc_div_chain.sv
// pipelined divider built as a row of restoring cells, one quotient bit each
module ttsc_div_chain
	import ttsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	input  ttsc_side_t        side_in,
	output logic [DATA_W-1:0] quotient,
	output logic [DATA_W-1:0] divisor_out,
	output ttsc_side_t        side_out
);

	ttsc_div_t stage [0:DIV_STEPS];

	// load the head of the chain with a fresh request
	always_comb begin
		stage[0].rem  = '0;
		stage[0].dvd  = dividend;
		stage[0].quo  = '0;
		stage[0].dvs  = divisor;
		stage[0].side = side_in;
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		ttsc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (stage[i]),
			.q      (stage[i+1])
		);
	end

	assign quotient    = stage[DIV_STEPS].quo;
	assign divisor_out = stage[DIV_STEPS].dvs;
	assign side_out    = stage[DIV_STEPS].side;

endmodule

>>> rtl/tone_timer_setting_calculator.sv
// top level: frequency in, pwm timer settings out, clock rate set over apb
// Each request (a tone frequency in hertz) passes through two pipelined
// restoring dividers of 32 cells each, one quotient bit per cell: ticks =
// clock_hz / frequency_hz first, then ticks / divider for the auto-reload
// count. Between them one register stage forms the prescaler divider from
// ticks / 65535, done by folding the upper half of ticks onto the lower half;
// one output register follows. A new request is taken every cycle; the whole
// pipeline holds while a result waits on out_ready. clock_hz resets to
// 16000000 and is changed by an apb write at address 0; the user must write
// it only while no request is in flight, as the block does not enforce this.
// A zero frequency gives an all-zero result; a frequency above clock_hz gives
// period 0 with too_high set.
module tone_timer_setting_calculator
	import ttsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// apb configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready,
	// request channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_W-1:0]     frequency_hz,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  timer_enable,
	output logic [PRESCALE_W-1:0] prescale_value,
	output logic [PERIOD_W-1:0]   period_value,
	output logic [COMPARE_W-1:0]  compare_value,
	output logic                  too_high
);

	logic [DATA_W-1:0]    clock_hz_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 en;

	ttsc_side_t           side_a;
	ttsc_side_t           side_b;
	ttsc_side_t           side_c;
	ttsc_side_t           side_d;
	logic [DATA_W-1:0]    ticks;
	logic [DATA_W-1:0]    period_quo;
	logic [DATA_W-1:0]    divider_out;
	logic [DATA_W-1:0]    unused_dvs_a;

	logic [DATA_W-LIMIT_W-1:0] tick_hi;
	logic [LIMIT_W-1:0]        tick_lo;
	logic [LIMIT_W:0]          fold;
	logic [1:0]                extra;
	logic [DATA_W-1:0]         limit_quo;
	logic [DATA_W-1:0]         divider_nxt;

	logic                 valid_s1;
	logic                 off_s1;
	logic [DATA_W-1:0]    ticks_s1;
	logic [DATA_W-1:0]    divider_s1;

	logic [DATA_W-1:0]    quo_m1;
	logic [DATA_W-1:0]    pre_m1;
	logic [PERIOD_W-1:0]  period_nxt;
	logic [PRESCALE_W-1:0] prescale_nxt;
	logic                 high_nxt;

	logic                  out_valid_q;
	logic                  timer_enable_q;
	logic [PRESCALE_W-1:0] prescale_q;
	logic [PERIOD_W-1:0]   period_q;
	logic                  too_high_q;

	// apb register file
	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_CLOCK_HZ) ? clock_hz_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLOCK_RESET;
		end else if (psel && penable && pwrite && pready && (reg_idx == REG_CLOCK_HZ)) begin
			clock_hz_q <= pwdata;
		end
	end

	// whole pipeline advances unless a finished result is stuck
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// ticks = clock / frequency
	always_comb begin
		side_a.valid = in_valid;
		side_a.off   = (frequency_hz == '0);
		side_a.aux   = '0;
	end

	ttsc_div_chain u_div_ticks (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.dividend    (clock_hz_q),
		.divisor     (frequency_hz),
		.side_in     (side_a),
		.quotient    (ticks),
		.divisor_out (unused_dvs_a),
		.side_out    (side_b)
	);

	// ticks / limit: the high half counts once per limit, the folded sum adds up to two more
	always_comb begin
		tick_hi   = ticks[DATA_W-1:LIMIT_W];
		tick_lo   = ticks[LIMIT_W-1:0];
		fold      = (LIMIT_W+1)'(tick_hi) + (LIMIT_W+1)'(tick_lo);
		if (fold >= FOLD_TWO) begin
			extra = 2'd2;
		end else if (fold >= FOLD_ONE) begin
			extra = 2'd1;
		end else begin
			extra = 2'd0;
		end
		limit_quo = DATA_W'(tick_hi) + DATA_W'(extra);
		divider_nxt = (ticks > PERIOD_LIMIT) ? (limit_quo + DATA_W'(1)) : DATA_W'(1);
	end

	// prescaler divider stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= side_b.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			off_s1     <= side_b.off;
			ticks_s1   <= ticks;
			divider_s1 <= divider_nxt;
		end
	end

	always_comb begin
		side_c.valid = valid_s1;
		side_c.off   = off_s1;
		side_c.aux   = ticks_s1;
	end

	// counts per cycle = ticks / divider
	ttsc_div_chain u_div_period (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.dividend    (side_c.aux),
		.divisor     (divider_s1),
		.side_in     (side_c),
		.quotient    (period_quo),
		.divisor_out (divider_out),
		.side_out    (side_d)
	);

	// final offsets and saturation
	always_comb begin
		quo_m1       = period_quo - DATA_W'(1);
		pre_m1       = divider_out - DATA_W'(1);
		high_nxt     = (period_quo == '0);
		if (high_nxt) begin
			period_nxt = '0;
		end else if (quo_m1 > DATA_W'(PERIOD_MAX)) begin
			period_nxt = PERIOD_MAX;
		end else begin
			period_nxt = quo_m1[PERIOD_W-1:0];
		end
		if (pre_m1 > DATA_W'(PRESCALE_MAX)) begin
			prescale_nxt = PRESCALE_MAX;
		end else begin
			prescale_nxt = pre_m1[PRESCALE_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= side_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			timer_enable_q <= !side_d.off;
			prescale_q     <= side_d.off ? '0 : prescale_nxt;
			period_q       <= side_d.off ? '0 : period_nxt;
			too_high_q     <= !side_d.off && high_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign timer_enable   = timer_enable_q;
	assign prescale_value = prescale_q;
	assign period_value   = period_q;
	assign compare_value  = period_q[PERIOD_W-1:1];
	assign too_high       = too_high_q;

	// checks
	a_high_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_high |-> timer_enable)
		else $error("too_high without timer_enable");

	a_high_period: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_high |-> (period_value == '0) && (prescale_value == '0))
		else $error("too_high with nonzero period or prescale");

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !timer_enable |->
			(prescale_value == '0) && (period_value == '0) && !too_high)
		else $error("tone off with nonzero settings");

	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while result stalled");

endmodule
